// ===== rtl/core/spp_pkg.sv =====
// Shared constants, types and register codes for the spectral peak picker.
package spp_pkg;

	// Build-time sizing
	localparam int MAX_BINS    = 1024;
	localparam int SCALE_SHIFT = 11;

	// Field widths
	localparam int BIN_W      = 24;
	localparam int SQ_W       = 2 * BIN_W - 1;
	localparam int SUM_W      = 2 * BIN_W;
	localparam int PWR_W      = SUM_W - SCALE_SHIFT;
	localparam int HEXT_W     = SUM_W + 1;
	localparam int CNT_W      = $clog2(MAX_BINS);
	localparam int DIST_W     = 11;
	localparam int POS_W      = ((CNT_W > DIST_W) ? CNT_W : DIST_W) + 2;
	localparam int HT_W       = 38;
	localparam int IDX_W      = 10;
	localparam int PKC_W      = 10;
	localparam int IN_DATA_W  = 2 * BIN_W;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = HT_W;

	// Constants
	localparam logic signed [POS_W-1:0] LAST_PEAK_INIT = POS_W'(-100);
	localparam logic [HT_W-1:0]         HT_MAX         = {HT_W{1'b1}};
	localparam logic [PKC_W-1:0]        PKC_MAX        = {PKC_W{1'b1}};
	localparam logic [DIST_W-1:0]       MIN_DIST_RST   = DIST_W'(1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_HEIGHT = 1'b0,
		CFG_MIN_DIST   = 1'b1
	} cfg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic [HT_W-1:0]   min_height;
		logic [DIST_W-1:0] min_dist;
	} cfg_t;

	// Power word passed from the power pipeline to the judge
	typedef struct packed {
		logic             last;
		logic [PWR_W-1:0] power;
	} pwr_word_t;

endpackage

// ===== rtl/core/spp_power.sv =====
// Three-stage bin power pipeline: input register, squares, scaled sum.
module spp_power (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [spp_pkg::BIN_W-1:0]        in_re,
	input  logic signed [spp_pkg::BIN_W-1:0]        in_im,
	input  logic                                    in_last,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output spp_pkg::pwr_word_t                      out_word
);
	import spp_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	logic                    rdy1, rdy2, rdy3;
	logic signed [BIN_W-1:0] re_s1, im_s1;
	logic                    last_s1, last_s2;
	logic [SQ_W-1:0]         sq_re_s2, sq_im_s2;
	logic signed [SUM_W-1:0] prod_re, prod_im;
	logic [SUM_W-1:0]        sum;
	pwr_word_t               word_s3;

	// Per-stage ready: a stage loads when empty or when drained below
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign prod_re = SUM_W'(re_s1) * SUM_W'(re_s1);
	assign prod_im = SUM_W'(im_s1) * SUM_W'(im_s1);
	assign sum     = SUM_W'(sq_re_s2) + SUM_W'(sq_im_s2);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			re_s1   <= in_re;
			im_s1   <= in_im;
			last_s1 <= in_last;
		end
		if (rdy2 && v_s1) begin
			sq_re_s2 <= prod_re[SQ_W-1:0];
			sq_im_s2 <= prod_im[SQ_W-1:0];
			last_s2  <= last_s1;
		end
		if (rdy3 && v_s2) begin
			word_s3.power <= sum[SUM_W-1:SCALE_SHIFT];
			word_s3.last  <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_word  = word_s3;

endmodule

// ===== rtl/core/spp_judge.sv =====
// Local-maximum judge with frame state and the result register.
module spp_judge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spp_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  spp_pkg::pwr_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_found,
	output logic [spp_pkg::IDX_W-1:0]         out_index,
	output logic [spp_pkg::HT_W-1:0]          out_height,
	output logic                              out_done,
	output logic [spp_pkg::PKC_W-1:0]         out_count
);
	import spp_pkg::*;

	logic [PWR_W-1:0]        prev_q, prev2_q;
	logic [CNT_W-1:0]        bin_cnt_q;
	logic signed [POS_W-1:0] last_pos_q;
	logic [PKC_W-1:0]        pk_cnt_q;

	logic                    fire;
	logic                    frame_end;
	logic                    is_max;
	logic [HEXT_W-1:0]       h_ext;
	logic [HT_W-1:0]         h_sat;
	logic [CNT_W-1:0]        cand;
	logic signed [POS_W-1:0] cand_s;
	logic signed [POS_W-1:0] last_plus;
	logic                    found;
	logic [PKC_W-1:0]        pk_cnt_nxt;

	logic                    valid_q;
	logic                    found_q, done_q;
	logic [IDX_W-1:0]        index_q;
	logic [HT_W-1:0]         height_q;
	logic [PKC_W-1:0]        count_q;

	assign in_ready = !valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	// Candidate test on the middle bin
	always_comb begin
		frame_end = in_word.last || (bin_cnt_q == CNT_W'(MAX_BINS - 1));
		is_max    = (bin_cnt_q >= CNT_W'(2)) && (prev2_q < prev_q) && (in_word.power < prev_q);
		h_ext     = (HEXT_W'(prev_q) - HEXT_W'(prev2_q)) + (HEXT_W'(prev_q) - HEXT_W'(in_word.power));
		h_sat     = (h_ext > HEXT_W'(HT_MAX)) ? HT_MAX : h_ext[HT_W-1:0];
		cand      = bin_cnt_q - CNT_W'(1);
		cand_s    = POS_W'(cand);
		last_plus = last_pos_q + $signed({{(POS_W-DIST_W){1'b0}}, cfg.min_dist});
		found     = is_max && (h_sat > cfg.min_height) && (cand_s > last_plus);
		pk_cnt_nxt = (found && (pk_cnt_q < PKC_MAX)) ? pk_cnt_q + PKC_W'(1) : pk_cnt_q;
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			prev2_q    <= '0;
			bin_cnt_q  <= '0;
			last_pos_q <= LAST_PEAK_INIT;
			pk_cnt_q   <= '0;
		end else if (fire) begin
			prev2_q <= prev_q;
			prev_q  <= in_word.power;
			if (frame_end) begin
				bin_cnt_q  <= '0;
				last_pos_q <= LAST_PEAK_INIT;
				pk_cnt_q   <= '0;
			end else begin
				bin_cnt_q <= bin_cnt_q + CNT_W'(1);
				pk_cnt_q  <= pk_cnt_nxt;
				if (found) last_pos_q <= cand_s;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= fire && (found || frame_end);
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			found_q  <= found;
			index_q  <= found ? IDX_W'(cand) : '0;
			height_q <= found ? h_sat : '0;
			done_q   <= frame_end;
			count_q  <= frame_end ? pk_cnt_nxt : '0;
		end
	end

	assign out_valid  = valid_q;
	assign out_found  = found_q;
	assign out_index  = index_q;
	assign out_height = height_q;
	assign out_done   = done_q;
	assign out_count  = count_q;

endmodule

// ===== rtl/core/spectral_peak_picker_unit.sv =====
// Top level of the spectral peak picker: config registers, power pipeline, judge.
// Throughput: one bin per cycle unless m_tready stalls the results, through the four-register
// pipeline (input register, 24x24 squares, scaled sum, judge/result stage).
// Words with no peak and no frame end produce no result.
// Reset clears all valids and frame state; thresholds return to 0 and 1.
module spectral_peak_picker_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [spp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Bin stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spp_pkg::IN_DATA_W-1:0]      s_tdata,  // bin_re[23:0], bin_im[47:24]
	input  logic                               s_tlast,  // last_bin
	// Peak stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spp_pkg::OUT_DATA_W-1:0]     m_tdata,  // peak_index[9:0],
	                                                     // peak_height_doubled[47:10],
	                                                     // peak_count[57:48], zeros
	output logic                               m_tlast,  // frame_done
	output logic                               m_tuser   // peak_found
);
	import spp_pkg::*;

	cfg_t             cfg_q;
	logic             pw_valid, pw_ready;
	pwr_word_t        pw_word;
	logic [IDX_W-1:0] peak_index;
	logic [HT_W-1:0]  peak_height;
	logic [PKC_W-1:0] peak_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_height <= '0;
			cfg_q.min_dist   <= MIN_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_HEIGHT: cfg_q.min_height <= cfg_data;
				CFG_MIN_DIST:   cfg_q.min_dist   <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	spp_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_re     (s_tdata[BIN_W-1:0]),
		.in_im     (s_tdata[2*BIN_W-1:BIN_W]),
		.in_last   (s_tlast),
		.out_valid (pw_valid),
		.out_ready (pw_ready),
		.out_word  (pw_word)
	);

	spp_judge u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (pw_valid),
		.in_ready   (pw_ready),
		.in_word    (pw_word),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_found  (m_tuser),
		.out_index  (peak_index),
		.out_height (peak_height),
		.out_done   (m_tlast),
		.out_count  (peak_count)
	);

	// Pack the result word
	assign m_tdata = {{(OUT_DATA_W - IDX_W - HT_W - PKC_W){1'b0}},
		peak_count, peak_height, peak_index};

endmodule

// ===== rtl/core/spp_checker.sv =====
// Port-level checker for the spectral peak picker, bound to the top level.
module spp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [spp_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	input  logic                           m_tuser
);
	import spp_pkg::*;

	localparam int CNT_LO = IDX_W + HT_W;

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result word changed while stalled");

	// Every result is a peak, a frame end, or both
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result with neither peak nor frame end");

	// No peak: index and height read zero
	a_nopeak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[CNT_LO-1:0] == '0)
		else $error("peak fields set without a peak");

	// Count only shows at frame end
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[CNT_LO+PKC_W-1:CNT_LO] == '0)
		else $error("peak count set before frame end");

	// A peak reported with the frame end is included in the count
	a_count_incl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> m_tdata[CNT_LO+PKC_W-1:CNT_LO] != '0)
		else $error("frame count misses peak in same result");

endmodule

bind spectral_peak_picker_unit spp_checker u_spp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
